// ----- src/sem2q_pkg.sv -----
// Shared types and codes for the two-queue semaphore waker.
// Used by semaphore_two_queue_waker_unit; depends on nothing else.
package sem2q_pkg;

    localparam int TidBits = 4;
    localparam int CfgBits = 16;

    typedef enum logic
    {
        OP_DOWN = 1'b0,
        OP_UP   = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_GRANTED  = 2'd0,
        ST_BLOCKED  = 2'd1,
        ST_RELEASED = 2'd2,
        ST_ERROR    = 2'd3
    } status_t;

    typedef enum logic
    {
        S_IDLE = 1'b0,
        S_WAKE = 1'b1
    } state_t;

    typedef struct packed
    {
        op_t                op;
        logic [TidBits-1:0] thread_id;
        logic               is_retry;
    } req_word_t;

    typedef struct packed
    {
        status_t            status;
        logic               wake_valid;
        logic [TidBits-1:0] wake_thread;
    } rsp_word_t;

endpackage

// ----- src/semaphore_two_queue_waker_unit.sv -----
// Counting semaphore with a normal and a priority wait queue of thread ids.
// Depends on sem2q_pkg and sem2q_ram.

// Each request word gives exactly one response word. A down request takes a
// unit or, with the count at zero, queues its thread id (priority queue when
// is_retry is set). An up request adds a unit and, when the count becomes one,
// pops and reports the head of the priority queue, else of the normal queue.
// Both queues live in RAMs with a registered read. An up that wakes a thread
// holds the block for an extra S_WAKE state: the woken id comes out of the
// queue RAM's read port in the cycle after the pop is issued.
// A new request is taken in the same cycle that the last response word is
// taken; while that word is stalled, req_stall stays high.
// A write on the cfg channel loads the count at once (saturated to the count
// width) and leaves the queues alone; it is meant for an idle block.
module semaphore_two_queue_waker_unit #(
    parameter int MAX_THREADS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sem2q_pkg::CfgBits-1:0]         cfg_data,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  sem2q_pkg::req_word_t                  req,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output sem2q_pkg::rsp_word_t                  rsp
);

    localparam int AW   = $clog2(MAX_THREADS);
    localparam int FW   = AW + 1;
    localparam int CfgW = (COUNT_BITS > sem2q_pkg::CfgBits) ? COUNT_BITS : sem2q_pkg::CfgBits;

    localparam logic [COUNT_BITS-1:0] CountMax = '1;
    localparam logic [FW-1:0]         QDepth   = FW'(MAX_THREADS);
    localparam logic [AW-1:0]         HeadLast = AW'(MAX_THREADS - 1);

    sem2q_pkg::state_t    state_reg, state_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [AW-1:0]        nhead_reg, nhead_next, phead_reg, phead_next;
    logic [FW-1:0]        nfill_reg, nfill_next, pfill_reg, pfill_next;
    logic                 wake_pri_reg, wake_pri_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    sem2q_pkg::rsp_word_t rsp_reg, rsp_next;

    logic                 accept;
    logic                 cfg_write;
    logic                 wake_go;
    logic [CfgW-1:0]      cfg_ext;
    logic [COUNT_BITS-1:0] cfg_count;

    // RAM ports
    logic                 n_we, p_we, n_re, p_re;
    logic [AW-1:0]        n_waddr, p_waddr, n_raddr, p_raddr;
    logic [sem2q_pkg::TidBits-1:0] n_rdata, p_rdata;

    logic [FW-1:0]        nsum, psum;
    logic [AW-1:0]        ntail, ptail;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;
    assign req_stall = (state_reg != sem2q_pkg::S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Saturate the written value to the count width.
    assign cfg_ext   = CfgW'(cfg_data);
    assign cfg_count = (cfg_ext > CfgW'(CountMax)) ? CountMax : COUNT_BITS'(cfg_ext);

    // Tail slot is head plus fill, wrapped once at the queue depth.
    assign nsum  = FW'(nhead_reg) + nfill_reg;
    assign psum  = FW'(phead_reg) + pfill_reg;
    assign ntail = (nsum >= QDepth) ? AW'(nsum - QDepth) : AW'(nsum);
    assign ptail = (psum >= QDepth) ? AW'(psum - QDepth) : AW'(psum);

    assign n_waddr = ntail;
    assign p_waddr = ptail;
    assign n_raddr = nhead_reg;
    assign p_raddr = phead_reg;

    // An up from a zero count with someone waiting pops a queue head.
    assign wake_go = accept && (req.op == sem2q_pkg::OP_UP) && (count_reg == '0)
                     && (count_reg != CountMax)
                     && ((pfill_reg != '0) || (nfill_reg != '0));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sem2q_pkg::S_IDLE:
            begin
                if (wake_go)
                begin
                    state_next = sem2q_pkg::S_WAKE;
                end
            end
            sem2q_pkg::S_WAKE:
            begin
                state_next = sem2q_pkg::S_IDLE;
            end
            default:
            begin
                state_next = sem2q_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        nhead_next     = nhead_reg;
        phead_next     = phead_reg;
        nfill_next     = nfill_reg;
        pfill_next     = pfill_reg;
        wake_pri_next  = wake_pri_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        n_we           = 1'b0;
        p_we           = 1'b0;
        n_re           = 1'b0;
        p_re           = 1'b0;

        case (state_reg)
            sem2q_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.wake_valid  = 1'b0;
                    rsp_next.wake_thread = '0;
                    rsp_valid_next       = 1'b1;
                    if (req.op == sem2q_pkg::OP_DOWN)
                    begin
                        if (count_reg != '0)
                        begin
                            count_next      = count_reg - 1'b1;
                            rsp_next.status = sem2q_pkg::ST_GRANTED;
                        end
                        else if (req.is_retry)
                        begin
                            if (pfill_reg != QDepth)
                            begin
                                p_we            = 1'b1;
                                pfill_next      = pfill_reg + 1'b1;
                                rsp_next.status = sem2q_pkg::ST_BLOCKED;
                            end
                            else
                            begin
                                rsp_next.status = sem2q_pkg::ST_ERROR;
                            end
                        end
                        else
                        begin
                            if (nfill_reg != QDepth)
                            begin
                                n_we            = 1'b1;
                                nfill_next      = nfill_reg + 1'b1;
                                rsp_next.status = sem2q_pkg::ST_BLOCKED;
                            end
                            else
                            begin
                                rsp_next.status = sem2q_pkg::ST_ERROR;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == CountMax)
                        begin
                            rsp_next.status = sem2q_pkg::ST_ERROR;
                        end
                        else
                        begin
                            count_next      = count_reg + 1'b1;
                            rsp_next.status = sem2q_pkg::ST_RELEASED;
                            if (wake_go)
                            begin
                                // The word is built in S_WAKE from the RAM data and registered from there.
                                rsp_valid_next = 1'b0;
                                wake_pri_next  = (pfill_reg != '0);
                                if (pfill_reg != '0)
                                begin
                                    p_re       = 1'b1;
                                    pfill_next = pfill_reg - 1'b1;
                                    phead_next = (phead_reg == HeadLast) ? '0
                                                 : phead_reg + 1'b1;
                                end
                                else
                                begin
                                    n_re       = 1'b1;
                                    nfill_next = nfill_reg - 1'b1;
                                    nhead_next = (nhead_reg == HeadLast) ? '0
                                                 : nhead_reg + 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            sem2q_pkg::S_WAKE:
            begin
                rsp_valid_next       = 1'b1;
                rsp_next.status      = sem2q_pkg::ST_RELEASED;
                rsp_next.wake_valid  = 1'b1;
                rsp_next.wake_thread = wake_pri_reg ? p_rdata : n_rdata;
            end
            default:
            begin
                rsp_valid_next = 1'b0;
            end
        endcase

        if (cfg_write)
        begin
            count_next = cfg_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sem2q_pkg::S_IDLE;
            count_reg     <= '0;
            nhead_reg     <= '0;
            phead_reg     <= '0;
            nfill_reg     <= '0;
            pfill_reg     <= '0;
            wake_pri_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            nhead_reg     <= nhead_next;
            phead_reg     <= phead_next;
            nfill_reg     <= nfill_next;
            pfill_reg     <= pfill_next;
            wake_pri_reg  <= wake_pri_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    sem2q_ram #(
        .WIDTH (sem2q_pkg::TidBits),
        .DEPTH (MAX_THREADS)
    ) u_normal_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (req.thread_id),
        .re    (n_re),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    sem2q_ram #(
        .WIDTH (sem2q_pkg::TidBits),
        .DEPTH (MAX_THREADS)
    ) u_priority_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (req.thread_id),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

endmodule

// ----- src/sem2q_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sem2q_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- tb/tb_semaphore_two_queue_waker_unit.sv -----
// Self-checking bench for the two-queue semaphore waker: predicts every response word
// from its own copy of the count and both wait queues under random stalls and gaps.
// Depends on sem2q_pkg and semaphore_two_queue_waker_unit.
module tb_semaphore_two_queue_waker_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WaitDepth = 16;
    localparam int QUEUE_NORMAL = 0;
    localparam int QUEUE_PRIORITY = 1;
    localparam int MIX_EVEN = 0;
    localparam int MIX_DOWNS = 1;
    localparam int MIX_UPS = 2;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [sem2q_pkg::CfgBits-1:0]  cfg_data;
    logic                           req_valid;
    logic                           req_stall;
    sem2q_pkg::req_word_t           req;
    logic                           rsp_valid;
    logic                           rsp_stall = 1'b0;
    sem2q_pkg::rsp_word_t           rsp;

    // Predicted semaphore state.
    logic [15:0]                    sem_count;
    logic [sem2q_pkg::TidBits-1:0]  wait_slot [2][WaitDepth];
    logic [sem2q_pkg::TidBits-1:0]  wait_head [2];
    int                             wait_fill [2];

    sem2q_pkg::rsp_word_t           semaphore_replies [$];
    logic [sem2q_pkg::TidBits-1:0]  woken_threads [$];
    int                             mismatch_count = 0;
    int                             quiet_left = 0;
    int                             hold_left = 0;

    semaphore_two_queue_waker_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic sem2q_pkg::rsp_word_t run_semaphore(input sem2q_pkg::req_word_t w);
        sem2q_pkg::rsp_word_t          r;
        int                            q;
        logic [sem2q_pkg::TidBits-1:0] pos;
        r = '0;
        q = w.is_retry ? QUEUE_PRIORITY : QUEUE_NORMAL;
        if (w.op == sem2q_pkg::OP_DOWN)
        begin
            if (sem_count != 16'd0)
            begin
                sem_count = sem_count - 1'b1;
                r.status = sem2q_pkg::ST_GRANTED;
            end
            else if (wait_fill[q] < WaitDepth)
            begin
                pos = wait_head[q] + sem2q_pkg::TidBits'(wait_fill[q]);
                wait_slot[q][pos] = w.thread_id;
                wait_fill[q]++;
                r.status = sem2q_pkg::ST_BLOCKED;
            end
            else
            begin
                r.status = sem2q_pkg::ST_ERROR;
            end
        end
        else if (sem_count == 16'hFFFF)
        begin
            r.status = sem2q_pkg::ST_ERROR;
        end
        else
        begin
            sem_count = sem_count + 1'b1;
            r.status = sem2q_pkg::ST_RELEASED;
            if (sem_count == 16'd1)
            begin
                q = (wait_fill[QUEUE_PRIORITY] != 0) ? QUEUE_PRIORITY : QUEUE_NORMAL;
                if (wait_fill[q] != 0)
                begin
                    r.wake_valid = 1'b1;
                    r.wake_thread = wait_slot[q][wait_head[q]];
                    wait_head[q] = wait_head[q] + 1'b1;
                    wait_fill[q]--;
                end
            end
        end
        return r;
    endfunction

    function automatic sem2q_pkg::req_word_t word_of(input sem2q_pkg::op_t op,
                                                     input logic [sem2q_pkg::TidBits-1:0] tid,
                                                     input logic retry);
        sem2q_pkg::req_word_t w;
        w.op = op;
        w.thread_id = tid;
        w.is_retry = retry;
        return w;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic sem2q_pkg::req_word_t make_request(input int mode);
        sem2q_pkg::req_word_t w;
        int                   down_pct;
        down_pct = (mode == MIX_DOWNS) ? 85 : (mode == MIX_UPS) ? 15 : 50;
        w.thread_id = sem2q_pkg::TidBits'($urandom_range(0, 15));
        w.is_retry = 1'($urandom_range(0, 1));
        if ($urandom_range(1, 100) <= down_pct)
        begin
            w.op = sem2q_pkg::OP_DOWN;
            // Half of the time a down brings a woken thread back, as a retry.
            if (woken_threads.size() != 0 && $urandom_range(0, 1) == 1)
            begin
                w.thread_id = woken_threads.pop_front();
                w.is_retry = 1'b1;
            end
            else
            begin
                w.is_retry = ($urandom_range(0, 3) == 0);
            end
        end
        else
        begin
            w.op = sem2q_pkg::OP_UP;
        end
        return w;
    endfunction

    function automatic void report_mismatch(input string what,
                                            input sem2q_pkg::rsp_word_t want,
                                            input sem2q_pkg::rsp_word_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"mismatch (%s) at %0t: expected status %0d wake %0b/%0d,",
                      " got status %0d wake %0b/%0d"},
                     what, $realtime, want.status, want.wake_valid, want.wake_thread,
                     got.status, got.wake_valid, got.wake_thread);
    endfunction

    // Valid stays high after a word is taken when the next one follows at once.
    task automatic send_request(input sem2q_pkg::req_word_t w);
        sem2q_pkg::rsp_word_t want;
        int                   gap;
        req_valid <= 1'b1;
        req <= w;
        do @(posedge clk); while (req_stall);
        want = run_semaphore(w);
        semaphore_replies.push_back(want);
        if (want.wake_valid)
            woken_threads.push_back(want.wake_thread);
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (semaphore_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_count(input logic [15:0] value);
        wait_drained();
        // A waking up holds the unit in its S_WAKE state.
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sem_count = value;
    endtask

    task automatic test_wake_order();
        send_request(word_of(sem2q_pkg::OP_UP, 4'd0, 1'b0));
        send_request(word_of(sem2q_pkg::OP_UP, 4'd15, 1'b1));
        send_request(word_of(sem2q_pkg::OP_DOWN, 4'd0, 1'b0));
        send_request(word_of(sem2q_pkg::OP_DOWN, 4'd15, 1'b1));
        send_request(word_of(sem2q_pkg::OP_DOWN, 4'd9, 1'b1));
        send_request(word_of(sem2q_pkg::OP_DOWN, 4'd6, 1'b0));
        send_request(word_of(sem2q_pkg::OP_UP, 4'd0, 1'b0));
        send_request(word_of(sem2q_pkg::OP_DOWN, 4'd9, 1'b1));
        send_request(word_of(sem2q_pkg::OP_UP, 4'd3, 1'b1));
    endtask

    task automatic test_full_wait_queue();
        load_count(16'd0);
        for (int i = 0; i < WaitDepth; i++)
            send_request(word_of(sem2q_pkg::OP_DOWN, sem2q_pkg::TidBits'(15 - i), 1'b0));
        send_request(word_of(sem2q_pkg::OP_DOWN, 4'd10, 1'b0));
    endtask

    task automatic test_saturated_count();
        load_count(16'hFFFF);
        send_request(word_of(sem2q_pkg::OP_UP, 4'd7, 1'b0));
        send_request(word_of(sem2q_pkg::OP_DOWN, 4'd8, 1'b0));
        send_request(word_of(sem2q_pkg::OP_UP, 4'd1, 1'b1));
    endtask

    task automatic test_random_traffic(input logic [15:0] start_count, input int n_items);
        int mode;
        int seg_left;
        mode = MIX_EVEN;
        seg_left = 0;
        load_count(start_count);
        for (int i = 0; i < n_items; i++)
        begin
            if (seg_left == 0)
            begin
                mode = $urandom_range(MIX_EVEN, MIX_UPS);
                seg_left = $urandom_range(20, 60);
            end
            seg_left--;
            if (i == n_items / 2)
                wait_drained();
            send_request(make_request(mode));
        end
    endtask

    // Receiver back-pressure: mostly short stalls, a few long ones, and quiet runs.
    always @(posedge clk)
    begin
        if (quiet_left > 0)
        begin
            rsp_stall <= 1'b0;
            quiet_left <= quiet_left - 1;
        end
        else if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            case ($urandom_range(0, 19))
                0:          quiet_left <= $urandom_range(20, 60);
                1:          hold_left <= $urandom_range(8, 30);
                2, 3, 4, 5: hold_left <= $urandom_range(1, 3);
                default:    ;
            endcase
        end
    end

    always @(posedge clk)
    begin : reply_check
        sem2q_pkg::rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (semaphore_replies.size() == 0)
            begin
                report_mismatch("word with nothing owed", '0, rsp);
            end
            else
            begin
                want = semaphore_replies.pop_front();
                if (rsp.status !== want.status || rsp.wake_valid !== want.wake_valid
                    || rsp.wake_thread !== want.wake_thread)
                    report_mismatch("field mismatch", want, rsp);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        req_valid = 1'b0;
        req = '0;
        sem_count = 16'd0;
        for (int q = 0; q < 2; q++)
        begin
            wait_head[q] = '0;
            wait_fill[q] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_wake_order();
        test_full_wait_queue();
        test_saturated_count();
        test_random_traffic(16'd0, 150);
        test_random_traffic(16'd1, 150);
        test_random_traffic(16'hFFFB, 100);
        test_random_traffic(16'($urandom), 100);
        test_random_traffic(16'd3, 150);
        test_random_traffic(16'd0, 150);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && semaphore_replies.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/sem2q_pkg.sv
src/sem2q_ram.sv
src/semaphore_two_queue_waker_unit.sv
tb/tb_semaphore_two_queue_waker_unit.sv
